// ===== src/irpcr_pkg.sv =====
// ----------------------------------------------------------------------------
// irpcr_pkg: shared types and constants for the IR pulse capture/replay block
// Fixed field widths, register reset value and the result beat layout.
// ----------------------------------------------------------------------------
`default_nettype none

package irpcr_pkg;

  // Width and reset value of the timeout register
  localparam int TIMEOUT_W = 20;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd40000;

  // Fixed widths of the result fields
  localparam int OUT_DUR_W = 20;
  localparam int OUT_CNT_W = 9;

  // One result beat
  typedef struct packed {
    logic                 tx_level;
    logic                 replaying;
    logic                 pulse_valid;
    logic                 pulse_level;
    logic [OUT_DUR_W-1:0] pulse_duration;
    logic                 frame_done;
    logic [OUT_CNT_W-1:0] pulses_held;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== src/irpcr_ram.sv =====
// ----------------------------------------------------------------------------
// irpcr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// Read data holds when no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module irpcr_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/ir_pulse_capture_replay.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_capture_replay: learn an IR remote frame and play it back
// Captures level/duration records into a pulse RAM, ends the frame on an
// idle timeout, then replays the records on the emitter output.
// ----------------------------------------------------------------------------
// Each input beat is one receiver sample (one tick) and yields exactly one
// result beat; the block takes one beat per clock cycle unless in_stall is
// high. While capturing, every level change writes one record into the
// pulse RAM while it has room; the idle timeout writes the final gap, ends
// the frame and starts replay at once (record 0 is fetched on the frame-end
// tick). During replay the RAM read port fetches each record ahead of its
// use, so a record with nonzero duration does not hold off input; each
// stored record of zero duration holds off input while the read port steps
// past it. A full result beat waiting on the output does not block the next
// input beat as long as the output register is drained in the same cycle.
// No clearing pass after reset: only written records are ever read back.
`default_nettype none

module ir_pulse_capture_replay
  import irpcr_pkg::*;
#(
  parameter int PULSE_DEPTH   = 256,
  parameter int DURATION_BITS = 20
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_rx_level,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_tx_level,
  output logic                      out_replaying,
  output logic                      out_pulse_valid,
  output logic                      out_pulse_level,
  output logic [OUT_DUR_W-1:0]      out_pulse_duration,
  output logic                      out_frame_done,
  output logic [OUT_CNT_W-1:0]      out_pulses_held,
  // configuration
  input  wire logic                 cfg_wr_en,
  input  wire logic [TIMEOUT_W-1:0] cfg_wr_data
);

  localparam int AW = (PULSE_DEPTH > 1) ? $clog2(PULSE_DEPTH) : 1;
  localparam int CW = $clog2(PULSE_DEPTH + 1);
  localparam int DW = DURATION_BITS;
  localparam int LW = (DW > TIMEOUT_W) ? DW : TIMEOUT_W;
  localparam logic [DW-1:0] DUR_MAX = {DW{1'b1}};
  localparam logic [CW-1:0] DEPTH_C = CW'(PULSE_DEPTH);

  // Registers
  logic [TIMEOUT_W-1:0] timeout_r;
  logic                 prior_r,    prior_nxt;
  logic [DW-1:0]        tse_r,      tse_nxt;
  logic [CW-1:0]        cnt_r,      cnt_nxt;
  logic                 replay_r,   replay_nxt;
  logic [CW-1:0]        idx_r,      idx_nxt;
  logic [DW-1:0]        rem_r,      rem_nxt;
  logic                 emit_r,     emit_nxt;
  logic                 rd_ok_r,    rd_ok_nxt;
  logic                 out_valid_r;
  out_beat_t            out_beat_r;

  // RAM interface
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW:0]   ram_rdata;

  // Datapath helpers
  logic          ent_lvl;
  logic [DW-1:0] ent_dur;
  logic          load;
  logic          ent_ok;
  logic          slot_free;
  logic          accept;
  logic          end_beat;
  logic [DW-1:0] tse_inc;
  logic [LW-1:0] limit;
  out_beat_t     beat;

  irpcr_ram #(
    .WIDTH (DW + 1),
    .DEPTH (PULSE_DEPTH),
    .AW    (AW)
  ) u_pulse_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Split the fetched record
  assign ent_lvl = ram_rdata[DW];
  assign ent_dur = ram_rdata[DW-1:0];

  // Handshake: hold input while the output slot is full or a zero-duration record is stepped past
  assign load      = replay_r && (rem_r == '0) && (idx_r < cnt_r);
  assign ent_ok    = rd_ok_r && (ent_dur != '0);
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !slot_free || (load && !ent_ok);
  assign accept    = in_valid && !in_stall;

  // Saturating tick count and effective timeout
  always_comb begin
    tse_inc = (tse_r == DUR_MAX) ? tse_r : tse_r + 1'b1;
    limit   = (timeout_r == '0) ? LW'(1) : LW'(timeout_r);
    if (limit > LW'(DUR_MAX)) begin
      limit = LW'(DUR_MAX);
    end
  end

  // Capture, replay sequencing and result beat
  always_comb begin
    prior_nxt  = prior_r;
    tse_nxt    = tse_r;
    cnt_nxt    = cnt_r;
    replay_nxt = replay_r;
    idx_nxt    = idx_r;
    rem_nxt    = rem_r;
    emit_nxt   = emit_r;
    rd_ok_nxt  = rd_ok_r;
    end_beat   = 1'b0;

    ram_we    = 1'b0;
    ram_waddr = cnt_r[AW-1:0];
    ram_wdata = {prior_r, tse_r};
    ram_re    = 1'b0;
    ram_raddr = idx_r[AW-1:0];

    beat                = '0;
    beat.tx_level       = emit_r;

    if (replay_r) begin
      if (load) begin
        if (rd_ok_r) begin
          // consume the fetched record and fetch the one after it
          idx_nxt   = idx_r + 1'b1;
          ram_re    = (idx_nxt < cnt_r);
          ram_raddr = idx_nxt[AW-1:0];
          if (ent_dur != '0) begin
            emit_nxt = ent_lvl;
            rem_nxt  = accept ? ent_dur - 1'b1 : ent_dur;
            if (accept) begin
              beat.tx_level  = ent_lvl;
              beat.replaying = 1'b1;
            end
          end
        end else begin
          // fetch the current record
          ram_re    = 1'b1;
          rd_ok_nxt = 1'b1;
        end
      end else if (rem_r != '0) begin
        // hold the current level
        if (accept) begin
          rem_nxt        = rem_r - 1'b1;
          beat.replaying = 1'b1;
        end
      end else if (accept) begin
        // drop the frame and re-arm capture
        end_beat      = 1'b1;
        emit_nxt      = 1'b0;
        cnt_nxt       = '0;
        prior_nxt     = 1'b1;
        tse_nxt       = '0;
        replay_nxt    = 1'b0;
        idx_nxt       = '0;
        rd_ok_nxt     = 1'b0;
        beat.tx_level = 1'b0;
      end
    end else if (accept) begin
      if (in_rx_level != prior_r) begin
        // level change: store the previous level and its duration
        if (cnt_r < DEPTH_C) begin
          ram_we              = 1'b1;
          cnt_nxt             = cnt_r + 1'b1;
          beat.pulse_valid    = 1'b1;
          beat.pulse_level    = prior_r;
          beat.pulse_duration = OUT_DUR_W'(tse_r);
        end
        prior_nxt = in_rx_level;
        tse_nxt   = DW'(1);
      end else begin
        tse_nxt = tse_inc;
        if ((cnt_r != '0) && (LW'(tse_inc) >= limit)) begin
          // idle timeout: store the final gap and start replay
          ram_wdata = {prior_r, tse_inc};
          if (cnt_r < DEPTH_C) begin
            ram_we              = 1'b1;
            cnt_nxt             = cnt_r + 1'b1;
            beat.pulse_valid    = 1'b1;
            beat.pulse_level    = prior_r;
            beat.pulse_duration = OUT_DUR_W'(tse_inc);
          end
          beat.frame_done = 1'b1;
          replay_nxt      = 1'b1;
          idx_nxt         = '0;
          rem_nxt         = '0;
          ram_re          = 1'b1;
          ram_raddr       = '0;
          rd_ok_nxt       = 1'b1;
        end
      end
    end

    beat.pulses_held = OUT_CNT_W'(cnt_nxt);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RESET;
      prior_r     <= 1'b1;
      tse_r       <= '0;
      cnt_r       <= '0;
      replay_r    <= 1'b0;
      idx_r       <= '0;
      rem_r       <= '0;
      emit_r      <= 1'b0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      prior_r     <= prior_nxt;
      tse_r       <= tse_nxt;
      cnt_r       <= cnt_nxt;
      replay_r    <= replay_nxt;
      idx_r       <= idx_nxt;
      rem_r       <= rem_nxt;
      emit_r      <= emit_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= accept ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
    end
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_beat_r <= beat;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tx_level       = out_beat_r.tx_level;
  assign out_replaying      = out_beat_r.replaying;
  assign out_pulse_valid    = out_beat_r.pulse_valid;
  assign out_pulse_level    = out_beat_r.pulse_level;
  assign out_pulse_duration = out_beat_r.pulse_duration;
  assign out_frame_done     = out_beat_r.frame_done;
  assign out_pulses_held    = out_beat_r.pulses_held;

  // Assertions
  a_no_write_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    replay_r |-> !ram_we)
    else $error("pulse RAM written during replay");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (cnt_r < DEPTH_C))
    else $error("pulse RAM written beyond its depth");

  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && beat.frame_done) |=> (replay_r && rd_ok_r && (idx_r == '0)))
    else $error("replay did not start with record 0 fetched");

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && end_beat) |=> ((cnt_r == '0) && !replay_r && prior_r))
    else $error("capture not re-armed after replay");

  a_rem_only_replay: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != '0) |-> replay_r)
    else $error("replay time left outside replay");

endmodule

`default_nettype wire
